[rtl/udiv_pkg.sv]
// Shared constants and types for the 64-bit unsigned divider.
// Used by udiv_seq and unsigned_divider_64; no dependencies.
`default_nettype none

package udiv_pkg;

  // Width of the operand and result ports.
  localparam int unsigned WORD_W = 64;

  // Default datapath width of the divider.
  localparam int unsigned DATA_WIDTH_DEF = 64;

  // Control strobes from the sequencer to the datapath.
  typedef struct packed {
    logic load;   // capture a new item from the input ports
    logic check;  // resolve the special cases
    logic run;    // perform one restoring step
  } udiv_ctrl_t;

endpackage : udiv_pkg

`default_nettype wire

[rtl/udiv_step.sv]
// One restoring division step: shift in a dividend bit, trial subtract, keep or restore.
// Purely combinational; used once by unsigned_divider_64 and shared over all steps.
`default_nettype none

module udiv_step #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic [DATA_WIDTH-1:0] rem_in,
  input  wire logic                  bit_in,
  input  wire logic [DATA_WIDTH-1:0] divisor_in,
  output logic      [DATA_WIDTH-1:0] rem_out,
  output logic                       take
);

  logic [DATA_WIDTH:0] shifted;
  logic [DATA_WIDTH:0] diff;

  // The bit shifted out of the partial remainder acts as a carry, so the
  // trial subtraction is one bit wider than the datapath.
  assign shifted = {rem_in, bit_in};
  assign diff    = shifted - {1'b0, divisor_in};
  assign take    = ~diff[DATA_WIDTH];
  assign rem_out = take ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];

endmodule : udiv_step

`default_nettype wire

[rtl/udiv_seq.sv]
// Sequencer of the divider: accepts an item, resolves special cases, counts the steps.
// Depends on udiv_pkg for the control struct.
`default_nettype none

module udiv_seq
  import udiv_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  input  wire logic   special,
  output udiv_ctrl_t  ctrl,
  output logic        busy,
  output logic        done
);

  localparam int unsigned CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_DONE
  } seq_state_t;

  seq_state_t       state;
  logic [CNT_W-1:0] cnt;

  // Strobes for the datapath.
  assign ctrl.load  = start & ~busy;
  assign ctrl.check = (state == ST_CHECK);
  assign ctrl.run   = (state == ST_RUN);

  // State, step counter and the registered handshake outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_CHECK;
            busy  <= 1'b1;
          end
        end
        ST_CHECK: begin
          if (special) begin
            state <= ST_DONE;
            done  <= 1'b1;
          end else begin
            state <= ST_RUN;
            cnt   <= LAST_STEP;
          end
        end
        ST_RUN: begin
          if (cnt == '0) begin
            state <= ST_DONE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        ST_DONE: begin
          state <= ST_IDLE;
          done  <= 1'b0;
          busy  <= 1'b0;
        end
        default: begin
          state <= ST_IDLE;
          done  <= 1'b0;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule : udiv_seq

`default_nettype wire

[rtl/unsigned_divider_64.sv]
// Unsigned divider: one item of dividend and divisor gives quotient, remainder and a
// divide-by-zero flag. An item is taken when start is high and busy is low. A normal
// division first checks for special cases, then gets one quotient bit per cycle from
// the single shared subtract unit, then gives the result in the cycle marked by done.
// A zero divisor, a divisor above the dividend or a divisor of one skips the steps and
// goes straight from the check to the result cycle.
// The result is valid only in the one cycle that done marks and cannot be held off,
// so the receiver must take it then. Busy stays high through the result cycle.
// A zero divisor sets divide_by_zero and returns quotient 0 and the dividend as
// remainder. Operand bits above DATA_WIDTH are ignored.
// Depends on udiv_pkg, udiv_step and udiv_seq.
`default_nettype none

module unsigned_divider_64
  import udiv_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic      [WORD_W-1:0] quotient,
  output logic      [WORD_W-1:0] remainder,
  output logic                   divide_by_zero
);

  udiv_ctrl_t            ctrl;
  logic                  special;
  logic                  div_zero;
  logic                  div_one;
  logic                  div_above;
  logic [DATA_WIDTH-1:0] quo_reg;   // dividend bits shift out, quotient bits shift in
  logic [DATA_WIDTH-1:0] rem_reg;
  logic [DATA_WIDTH-1:0] dsr_reg;
  logic                  dz_reg;
  logic [DATA_WIDTH-1:0] rem_next;
  logic                  take;

  // Sequencer.
  udiv_seq #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .special(special),
    .ctrl   (ctrl),
    .busy   (busy),
    .done   (done)
  );

  // Shared restoring step unit.
  udiv_step #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_step (
    .rem_in    (rem_reg),
    .bit_in    (quo_reg[DATA_WIDTH-1]),
    .divisor_in(dsr_reg),
    .rem_out   (rem_next),
    .take      (take)
  );

  // Special cases, looked at in the check cycle.
  assign div_zero  = (dsr_reg == '0);
  assign div_one   = (dsr_reg == DATA_WIDTH'(1));
  assign div_above = (dsr_reg > quo_reg);
  assign special   = div_zero | div_one | div_above;

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      quo_reg <= dividend[DATA_WIDTH-1:0];
      dsr_reg <= divisor[DATA_WIDTH-1:0];
      rem_reg <= '0;
      dz_reg  <= 1'b0;
    end else if (ctrl.check) begin
      dz_reg <= div_zero;
      if (div_one) begin
        rem_reg <= '0;
      end else if (div_zero | div_above) begin
        rem_reg <= quo_reg;
        quo_reg <= '0;
      end
    end else if (ctrl.run) begin
      rem_reg <= rem_next;
      quo_reg <= {quo_reg[DATA_WIDTH-2:0], take};
    end
  end

  // Result ports, zero-extended to the port width.
  assign quotient       = WORD_W'(quo_reg);
  assign remainder      = WORD_W'(rem_reg);
  assign divide_by_zero = dz_reg;

  // A result only appears while the block is busy.
  assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done outside a busy period");

  // An accepted item makes the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // The strobe lasts exactly one cycle.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // A division by zero returns a zero quotient.
  assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero) |-> (quotient == '0))
    else $error("nonzero quotient on divide by zero");

  // A real division leaves a remainder below the divisor.
  assert property (@(posedge clk) disable iff (rst)
    (done && !divide_by_zero) |-> (rem_reg < dsr_reg))
    else $error("remainder not below divisor");

endmodule : unsigned_divider_64

`default_nettype wire
